// ----- rtl/core/bchd_pkg.sv -----
// Package for the button click/hold detector.
// Types, register indexes, event codes and small helper functions.
// No dependencies.
package bchd_pkg;

   localparam int unsigned DebW   = 8;
   localparam int unsigned TickW  = 16;
   localparam int unsigned CntW   = 9;
   localparam int unsigned EdgeW  = 6;
   localparam int unsigned CodeW  = 3;
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 16;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DEBOUNCE_SAMPLES = 2'd0,
      CSR_GAP_TICKS        = 2'd1,
      CSR_HOLD_TICKS       = 2'd2
   } csr_index_type;

   typedef enum logic [CodeW-1:0] {
      EV_SINGLE = 3'd0,
      EV_DOUBLE = 3'd1,
      EV_TRIPLE = 3'd2,
      EV_MANY   = 3'd3,
      EV_HOLD   = 3'd4
   } event_type;

   localparam logic [DebW-1:0]  RstDebounceSamples = 8'd4;
   localparam logic [TickW-1:0] RstGapTicks        = 16'd300;
   localparam logic [TickW-1:0] RstHoldTicks       = 16'd1000;
   localparam logic [EdgeW-1:0] EdgeMax            = 6'd63;
   localparam logic [EdgeW-1:0] EdgeWrap           = 6'd62;

   typedef struct packed {
      logic [DebW-1:0]  debounce_samples;
      logic [TickW-1:0] gap_ticks;
      logic [TickW-1:0] hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic [CntW-1:0]  debounce_count;
      logic [EdgeW-1:0] edge_count;
      logic [TickW-1:0] gap_timer;
      logic             gap_running;
      logic [TickW-1:0] hold_timer;
      logic             hold_running;
   } state_type;

   typedef struct packed {
      logic      valid;
      event_type code;
   } event_out_type;

   function automatic logic [DebW-1:0] min_one_8(input logic [DebW-1:0] v);
      return (v == '0) ? DebW'(1) : v;
   endfunction

   function automatic logic [TickW-1:0] min_one_16(input logic [TickW-1:0] v);
      return (v == '0) ? TickW'(1) : v;
   endfunction

   function automatic event_type click_code(input logic [EdgeW-1:0] count);
      case (count)
         6'd2:    return EV_SINGLE;
         6'd4:    return EV_DOUBLE;
         6'd6:    return EV_TRIPLE;
         default: return EV_MANY;
      endcase
   endfunction

endpackage

// ----- rtl/core/bchd_if.sv -----
// Channel interfaces for the button click/hold detector.
// Depends on bchd_pkg.
interface bchd_req_if;
   logic valid;
   logic ready;
   logic pin_level;
   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

interface bchd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bchd_pkg::CodeW-1:0]   event_code;
   modport source (output valid, output event_code, input ready);
   modport sink   (input valid, input event_code, output ready);
endinterface

// ----- rtl/core/bchd_step.sv -----
// Next-state logic for one sample tick: gap timer, hold timer, debounce, edge.
// Depends on bchd_pkg.
module bchd_step (
   input  bchd_pkg::cfg_type       cfg,
   input  bchd_pkg::state_type     cur,
   input  logic                    pin_level,
   output bchd_pkg::state_type     nxt,
   output bchd_pkg::event_out_type evt
);

   always_comb begin
      logic [bchd_pkg::CntW-1:0] s;
      logic [bchd_pkg::CntW-1:0] s2;
      bchd_pkg::state_type       st;
      bchd_pkg::event_out_type   ev;

      s  = {1'b0, bchd_pkg::min_one_8(cfg.debounce_samples)};
      s2 = {s[bchd_pkg::CntW-2:0], 1'b0};
      st = cur;
      ev.valid = 1'b0;
      ev.code  = bchd_pkg::EV_SINGLE;

      if (st.gap_running) begin
         if (st.gap_timer <= bchd_pkg::TickW'(1)) begin
            st.gap_running = 1'b0;
            st.gap_timer   = '0;
            if (!st.edge_count[0]) begin
               ev.valid = 1'b1;
               ev.code  = bchd_pkg::click_code(st.edge_count);
            end
            st.edge_count = '0;
         end else begin
            st.gap_timer = st.gap_timer - bchd_pkg::TickW'(1);
         end
      end

      if (st.hold_running) begin
         if (st.hold_timer <= bchd_pkg::TickW'(1)) begin
            st.hold_timer = bchd_pkg::min_one_16(cfg.hold_ticks);
            if (!ev.valid) begin
               ev.valid = 1'b1;
               ev.code  = bchd_pkg::EV_HOLD;
            end
         end else begin
            st.hold_timer = st.hold_timer - bchd_pkg::TickW'(1);
         end
      end

      if (pin_level) begin
         st.debounce_count = (st.debounce_count < s)
                           ? st.debounce_count + bchd_pkg::CntW'(1) : s2;
      end else begin
         st.debounce_count = (st.debounce_count > s)
                           ? st.debounce_count - bchd_pkg::CntW'(1) : '0;
      end

      if (st.debounce_count == s) begin
         st.debounce_count = pin_level ? s2 : '0;
         st.edge_count     = (st.edge_count >= bchd_pkg::EdgeMax)
                           ? bchd_pkg::EdgeWrap
                           : st.edge_count + bchd_pkg::EdgeW'(1);
         st.gap_timer      = bchd_pkg::min_one_16(cfg.gap_ticks);
         st.gap_running    = 1'b1;
         if (pin_level) begin
            st.hold_timer   = bchd_pkg::min_one_16(cfg.hold_ticks);
            st.hold_running = 1'b1;
         end else begin
            st.hold_timer   = '0;
            st.hold_running = 1'b0;
         end
      end

      nxt = st;
      evt = ev;
   end

endmodule

// ----- rtl/core/button_click_hold_detector.sv -----
// Button click/hold detector top level: config registers, state, result register.
// Depends on bchd_pkg, bchd_if.sv and bchd_step.
//
// Each accepted item is one sample tick of the raw button level. The tick is
// processed in the cycle it is accepted and any click or hold event appears in
// the result register on the next cycle. One item is taken every cycle; the
// input stalls only while an event waits in the result register and rsp is not
// ready. Configuration writes take effect for the next item.
module button_click_hold_detector (
   input  logic                              clock,
   input  logic                              reset,
   bchd_req_if.sink                          req_chan,
   bchd_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [bchd_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [bchd_pkg::CsrDataW-1:0]     csr_write_data
);

   bchd_pkg::cfg_type       cfg_ff;
   bchd_pkg::state_type     state_ff;
   bchd_pkg::state_type     state_in;
   bchd_pkg::event_out_type evt;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   bchd_pkg::event_type     rsp_code_ff;
   logic                    accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   bchd_step u_step (
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .pin_level (req_chan.pin_level),
      .nxt       (state_in),
      .evt       (evt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_samples <= bchd_pkg::RstDebounceSamples;
         cfg_ff.gap_ticks        <= bchd_pkg::RstGapTicks;
         cfg_ff.hold_ticks       <= bchd_pkg::RstHoldTicks;
      end else if (csr_write_enable) begin
         case (csr_index)
            bchd_pkg::CSR_DEBOUNCE_SAMPLES:
               cfg_ff.debounce_samples <= csr_write_data[bchd_pkg::DebW-1:0];
            bchd_pkg::CSR_GAP_TICKS:
               cfg_ff.gap_ticks <= csr_write_data;
            bchd_pkg::CSR_HOLD_TICKS:
               cfg_ff.hold_ticks <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && evt.valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && evt.valid) begin
         rsp_code_ff <= evt.code;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.event_code = rsp_code_ff;

endmodule

// ----- tb/button_click_hold_detector_checker.sv -----
`timescale 1ns / 1ps
// Event checker for the button click/hold detector: tracks the register writes,
// predicts the event of every accepted tick and compares the returned events in order.
// Depends on bchd_pkg and bchd_if.sv.
module button_click_hold_detector_checker (
   input  logic                          clock,
   input  logic                          reset,
   bchd_req_if                           req_mon,
   bchd_rsp_if                           rsp_mon,
   input  logic                          csr_write_enable,
   input  logic [bchd_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [bchd_pkg::CsrDataW-1:0] csr_write_data,
   output int                            events_outstanding,
   output int                            failures
);

   localparam int ReportCap = 100;

   logic [bchd_pkg::DebW-1:0]  cfg_samples;
   logic [bchd_pkg::TickW-1:0] cfg_gap;
   logic [bchd_pkg::TickW-1:0] cfg_hold;

   logic [bchd_pkg::CntW-1:0]  deb_cnt;
   logic [bchd_pkg::EdgeW-1:0] press_edges;
   logic [bchd_pkg::TickW-1:0] gap_left;
   logic                       gap_on;
   logic [bchd_pkg::TickW-1:0] hold_left;
   logic                       hold_on;

   bchd_pkg::event_type pending_events[$];
   int                  mismatches = 0;

   // Advances the detector by one tick; returns 1 when the tick yields an event.
   function automatic bit next_event(input logic level, output bchd_pkg::event_type code);
      logic [bchd_pkg::CntW-1:0]  span;
      logic [bchd_pkg::TickW-1:0] gap_load;
      logic [bchd_pkg::TickW-1:0] hold_load;
      bit                         fired;
      span      = (cfg_samples == '0) ? bchd_pkg::CntW'(1) : bchd_pkg::CntW'(cfg_samples);
      gap_load  = (cfg_gap == '0) ? bchd_pkg::TickW'(1) : cfg_gap;
      hold_load = (cfg_hold == '0) ? bchd_pkg::TickW'(1) : cfg_hold;
      fired     = 1'b0;
      code      = bchd_pkg::EV_SINGLE;

      if (gap_on) begin
         if (gap_left <= bchd_pkg::TickW'(1)) begin
            gap_on   = 1'b0;
            gap_left = '0;
            if (!press_edges[0]) begin
               fired = 1'b1;
               case (press_edges)
                  6'd2:    code = bchd_pkg::EV_SINGLE;
                  6'd4:    code = bchd_pkg::EV_DOUBLE;
                  6'd6:    code = bchd_pkg::EV_TRIPLE;
                  default: code = bchd_pkg::EV_MANY;
               endcase
            end
            press_edges = '0;
         end else begin
            gap_left = gap_left - bchd_pkg::TickW'(1);
         end
      end

      // click wins over a hold in the same tick; hold timer reloads anyway
      if (hold_on) begin
         if (hold_left <= bchd_pkg::TickW'(1)) begin
            hold_left = hold_load;
            if (!fired) begin
               fired = 1'b1;
               code  = bchd_pkg::EV_HOLD;
            end
         end else begin
            hold_left = hold_left - bchd_pkg::TickW'(1);
         end
      end

      if (level) begin
         deb_cnt = (deb_cnt < span) ? deb_cnt + bchd_pkg::CntW'(1) : span + span;
      end else begin
         deb_cnt = (deb_cnt > span) ? deb_cnt - bchd_pkg::CntW'(1) : '0;
      end

      if (deb_cnt == span) begin
         deb_cnt     = level ? span + span : '0;
         press_edges = (press_edges == bchd_pkg::EdgeMax)
                     ? bchd_pkg::EdgeWrap : press_edges + bchd_pkg::EdgeW'(1);
         gap_left    = gap_load;
         gap_on      = 1'b1;
         if (level) begin
            hold_left = hold_load;
            hold_on   = 1'b1;
         end else begin
            hold_left = '0;
            hold_on   = 1'b0;
         end
      end
      return fired;
   endfunction

   always @(posedge clock) begin
      bchd_pkg::event_type code;
      bchd_pkg::event_type want;
      if (reset) begin
         cfg_samples = bchd_pkg::RstDebounceSamples;
         cfg_gap     = bchd_pkg::RstGapTicks;
         cfg_hold    = bchd_pkg::RstHoldTicks;
         deb_cnt     = '0;
         press_edges = '0;
         gap_left    = '0;
         gap_on      = 1'b0;
         hold_left   = '0;
         hold_on     = 1'b0;
         pending_events.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               bchd_pkg::CSR_DEBOUNCE_SAMPLES:
                  cfg_samples = csr_write_data[bchd_pkg::DebW-1:0];
               bchd_pkg::CSR_GAP_TICKS:  cfg_gap = csr_write_data;
               bchd_pkg::CSR_HOLD_TICKS: cfg_hold = csr_write_data;
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_events.size() == 0) begin
               mismatches++;
               if (mismatches <= ReportCap)
                  $error("event_code: expected no item, actual %0d", rsp_mon.event_code);
            end else begin
               want = pending_events.pop_front();
               if (rsp_mon.event_code !== want) begin
                  mismatches++;
                  if (mismatches <= ReportCap)
                     $error("event_code: expected %0d, actual %0d", want, rsp_mon.event_code);
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            if (next_event(req_mon.pin_level, code))
               pending_events.push_back(code);
         end
      end
      events_outstanding <= pending_events.size();
      failures           <= mismatches + pending_events.size();
   end

endmodule

// ----- tb/button_click_hold_detector_test.sv -----
`timescale 1ns / 1ps
// Top of the button click/hold detector testbench: clock, reset, register writes,
// tick stimulus and response back-pressure; the verdict comes from the event checker.
// Depends on bchd_pkg, bchd_if.sv, button_click_hold_detector and its checker.
module button_click_hold_detector_test;

   localparam int CycleLimit = 500000;
   localparam int ModeItems  = 30;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_write_enable;
   logic [bchd_pkg::CsrIdxW-1:0]  csr_index;
   logic [bchd_pkg::CsrDataW-1:0] csr_write_data;

   int events_outstanding;
   int failures;

   int send_idle_pct;
   int recv_stall_pct;
   int items_sent  = 0;
   int cycle_count = 0;
   int eff_samples;
   int eff_gap;
   int eff_hold;

   bchd_req_if req_bus ();
   bchd_rsp_if rsp_bus ();

   button_click_hold_detector u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   button_click_hold_detector_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_bus),
      .rsp_mon            (rsp_bus),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .events_outstanding (events_outstanding),
      .failures           (failures)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_level(input logic level);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid     <= 1'b0;
         req_bus.pin_level <= 1'($urandom_range(1));
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.pin_level <= level;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (events_outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input int samples, input int gap, input int hold);
      csr_write_enable <= 1'b1;
      csr_index        <= bchd_pkg::CSR_DEBOUNCE_SAMPLES;
      csr_write_data   <= {8'($urandom_range(255)), 8'(samples)};
      @(posedge clock);
      csr_index      <= bchd_pkg::CSR_GAP_TICKS;
      csr_write_data <= 16'(gap);
      @(posedge clock);
      csr_index      <= bchd_pkg::CSR_HOLD_TICKS;
      csr_write_data <= 16'(hold);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      eff_samples = (samples == 0) ? 1 : samples;
      eff_gap     = (gap == 0) ? 1 : gap;
      eff_hold    = (hold == 0) ? 1 : hold;
   endtask

   task automatic shuffle_config();
      drain_results();
      set_config(($urandom_range(7) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1),
                 $urandom_range(16, 1), $urandom_range(24, 1));
   endtask

   // presses with random lengths; the last release is long enough for the click report
   task automatic press_train(input int presses, input bit bouncy);
      int on_len;
      int off_len;
      for (int k = 0; k < presses; k++) begin
         on_len = $urandom_range(eff_samples + 2 * eff_hold, 1);
         repeat (on_len) send_level((bouncy && $urandom_range(15) == 0) ? 1'b0 : 1'b1);
         off_len = (k == presses - 1) ? eff_samples + eff_gap + 2
                                      : $urandom_range(eff_samples + eff_gap + 2, 1);
         repeat (off_len) send_level((bouncy && $urandom_range(15) == 0) ? 1'b1 : 1'b0);
      end
   endtask

   initial begin
      logic [23:0] warmup;
      int          mode_start;
      warmup = 24'b1111111_0000_10_000_1010_0000;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.pin_level <= 1'b0;
      csr_write_enable  <= 1'b0;
      csr_index         <= bchd_pkg::CSR_DEBOUNCE_SAMPLES;
      csr_write_data    <= '0;
      eff_samples       = 4;
      eff_gap           = 300;
      eff_hold          = 1000;
      send_idle_pct     = 22;
      recv_stall_pct    = 75;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // short presses, a hold, odd count at expiry, single and double clicks
      set_config(1, 3, 4);
      for (int i = 23; i >= 0; i--) send_level(warmup[i]);
      drain_results();

      // zero registers behave as one
      set_config(0, 0, 0);
      press_train(3, 1'b0);
      repeat (12) send_level(1'($urandom_range(1)));
      drain_results();

      // press count saturation, even and odd at expiry
      set_config(1, 4, 65535);
      repeat (3) send_level(1'b0);
      for (int k = 0; k < 70; k++) send_level(k % 2 == 0);
      repeat (8) send_level(1'b0);
      for (int k = 0; k < 71; k++) send_level(k % 2 == 0);
      repeat (8) send_level(1'b0);
      drain_results();

      // longest debounce
      set_config(255, 2, 300);
      repeat (260) send_level(1'b1);
      repeat (260) send_level(1'b0);
      drain_results();

      // hold every tick, gap never runs out
      set_config(1, 65535, 1);
      repeat (30) send_level(1'b1);
      repeat (3) send_level(1'b0);
      repeat (5) send_level(1'b1);
      repeat (2) send_level(1'b0);

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct  = (mode == 0) ? 22 : (mode == 1) ? 75 : 0;
         recv_stall_pct = (mode == 0) ? 75 : (mode == 1) ? 22 : 0;
         shuffle_config();
         mode_start = items_sent;
         while (items_sent - mode_start < ModeItems) begin
            if ($urandom_range(5) == 0) shuffle_config();
            case ($urandom_range(9))
               0, 1:    repeat ($urandom_range(16, 1)) send_level(1'($urandom_range(1)));
               2:       press_train($urandom_range(8, 4), $urandom_range(1) == 0);
               default: press_train($urandom_range(3, 1), $urandom_range(3) == 0);
            endcase
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
